// ===== rtl/srht_pkg.sv =====
// shared types, constants and codes for the screen region hit test
// no dependencies; every other file imports this package
`default_nettype none

package srht_pkg;

  localparam int MAX_VERTICES  = 32;
  localparam int FRACTION_BITS = 4;

  localparam int COORD_W = 20;
  localparam int PIX_W   = 15;
  localparam int PIXQ_W  = PIX_W + FRACTION_BITS;
  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int SHAPE_W = 2;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  // multiplier operand width covers 2p - s - e and every edge difference
  localparam int MUL_W   = (COORD_W + 2 > PIXQ_W + 3) ? COORD_W + 2 : PIXQ_W + 3;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int MIN_POLY = 3;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_SHAPE   = 3'd0,
    REG_START_X = 3'd1,
    REG_START_Y = 3'd2,
    REG_END_X   = 3'd3,
    REG_END_Y   = 3'd4
  } reg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_TEST  = 2'd0,
    OP_ADD   = 2'd1,
    OP_UNDO  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_RECT   = 2'd0,
    SHAPE_CIRCLE = 2'd1,
    SHAPE_POLY   = 2'd2,
    SHAPE_NONE   = 2'd3
  } shape_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_SHORT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POLY,
    S_DRAIN,
    S_CIRC_A,
    S_CIRC_B,
    S_CIRC_C,
    S_CIRC_D,
    S_FIN
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

endpackage

`default_nettype wire

// ===== rtl/srht_if.sv =====
// valid/ready channel interfaces for input items and result items
// depends on srht_pkg
`default_nettype none

interface srht_in_if import srht_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           opcode;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;

  modport source (output valid, opcode, coord_x, coord_y, input ready);
  modport sink   (input valid, opcode, coord_x, coord_y, output ready);
endinterface

interface srht_out_if import srht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              inside_res;
  logic [CNT_W-1:0]  vertex_count;
  logic [STAT_W-1:0] status;

  modport source (output valid, inside_res, vertex_count, status, input ready);
  modport sink   (input valid, inside_res, vertex_count, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/srht_cell.sv =====
// one vertex cell of the rotating vertex ring
// depends on srht_pkg
`default_nettype none

module srht_cell import srht_pkg::*; (
  input  wire logic    clk,
  input  wire logic    load_en,
  input  wire vertex_t load_v,
  input  wire logic    shift_en,
  input  wire vertex_t shift_in,
  output vertex_t      q
);

  always_ff @(posedge clk) begin
    if (load_en) begin
      q <= load_v;
    end else if (shift_en) begin
      q <= shift_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srht_mul.sv =====
// shared two-product multiply stage with registered products
// depends on srht_pkg
`default_nettype none

module srht_mul import srht_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_v,
  input  wire logic signed [MUL_W-1:0] a1,
  input  wire logic signed [MUL_W-1:0] b1,
  input  wire logic signed [MUL_W-1:0] a2,
  input  wire logic signed [MUL_W-1:0] b2,
  output logic                         out_v,
  output logic signed [PROD_W-1:0]     p1,
  output logic signed [PROD_W-1:0]     p2
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    p1 <= a1 * b1;
    p2 <= a2 * b2;
  end

endmodule

`default_nettype wire

// ===== rtl/screen_region_hit_test.sv =====
// screen region hit test: rectangle, circle or polygon region, vertex ring store
// path to the output register: add/undo/clear/rectangle/short polygon through S_FIN,
// circle through S_CIRC_A to S_CIRC_D then S_FIN, polygon through S_POLY over the ring, S_DRAIN, S_FIN
// throughput: one transaction in flight, the next one taken the cycle after the result
// loads; polygon set by the full ring rotation and the drain of the multiply stage
// reset (synchronous, rst high) clears registers, vertex count and control; no sweep
`default_nettype none

module screen_region_hit_test import srht_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  srht_in_if.sink                in_ch,
  srht_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  // ---------------- configuration registers ----------------
  logic [SHAPE_W-1:0] region_shape;
  logic [PIX_W-1:0]   drag_start_x, drag_start_y, drag_end_x, drag_end_y;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      region_shape <= '0;
      drag_start_x <= '0;
      drag_start_y <= '0;
      drag_end_x   <= '0;
      drag_end_y   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SHAPE:   region_shape <= pwdata[SHAPE_W-1:0];
        REG_START_X: drag_start_x <= pwdata[PIX_W-1:0];
        REG_START_Y: drag_start_y <= pwdata[PIX_W-1:0];
        REG_END_X:   drag_end_x   <= pwdata[PIX_W-1:0];
        REG_END_Y:   drag_end_y   <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SHAPE:   prdata = DATA_W'(region_shape);
      REG_START_X: prdata = DATA_W'(drag_start_x);
      REG_START_Y: prdata = DATA_W'(drag_start_y);
      REG_END_X:   prdata = DATA_W'(drag_end_x);
      REG_END_Y:   prdata = DATA_W'(drag_end_y);
      default:     prdata = '0;
    endcase
  end

  // drag points moved into the point format, zero-extended to the multiply width
  logic signed [MUL_W-1:0] sxq, syq, exq, eyq;
  assign sxq = signed'(MUL_W'({drag_start_x, {FRACTION_BITS{1'b0}}}));
  assign syq = signed'(MUL_W'({drag_start_y, {FRACTION_BITS{1'b0}}}));
  assign exq = signed'(MUL_W'({drag_end_x, {FRACTION_BITS{1'b0}}}));
  assign eyq = signed'(MUL_W'({drag_end_y, {FRACTION_BITS{1'b0}}}));

  // ---------------- control state ----------------
  state_e             state, state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   step;
  logic               accept;
  opcode_e            in_op;
  shape_e             shape;
  logic               fin_load;
  logic               edge_v, mul_v;

  assign in_op  = opcode_e'(in_ch.opcode);
  assign shape  = shape_e'(region_shape);
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign fin_load = (state == S_FIN) && (!out_ch.valid || out_ch.ready);

  // rectangle test straight off the input coordinates
  logic signed [MUL_W-1:0] in_x, in_y;
  logic                    rect_hit;
  assign in_x = MUL_W'(in_ch.coord_x);
  assign in_y = MUL_W'(in_ch.coord_y);
  assign rect_hit = ((sxq < exq) ? (in_x >= sxq && in_x <= exq) : (in_x >= exq && in_x <= sxq))
                 && ((syq < eyq) ? (in_y >= syq && in_y <= eyq) : (in_y >= eyq && in_y <= syq));

  // ---------------- vertex ring ----------------
  vertex_t ring_q [MAX_VERTICES];
  vertex_t in_vtx;
  logic    add_ok;
  logic    shift_en;

  assign in_vtx.x = in_ch.coord_x;
  assign in_vtx.y = in_ch.coord_y;
  assign add_ok   = accept && (in_op == OP_ADD) && (count < CNT_W'(MAX_VERTICES));
  assign shift_en = (state == S_POLY) && (step < CNT_W'(MAX_VERTICES));

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    srht_cell u_cell (
      .clk      (clk),
      .load_en  (add_ok && (count == CNT_W'(k))),
      .load_v   (in_vtx),
      .shift_en (shift_en),
      .shift_in (ring_q[(k + 1) % MAX_VERTICES]),
      .q        (ring_q[k])
    );
  end

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_op == OP_TEST && shape == SHAPE_CIRCLE) begin
          state_next = S_CIRC_A;
        end else if (accept && in_op == OP_TEST && shape == SHAPE_POLY
                     && count >= CNT_W'(MIN_POLY)) begin
          state_next = S_POLY;
        end else if (accept) begin
          state_next = S_FIN;
        end
      end
      S_POLY:   if (step == CNT_W'(MAX_VERTICES)) state_next = S_DRAIN;
      S_DRAIN:  if (!edge_v && !mul_v) state_next = S_FIN;
      S_CIRC_A: state_next = S_CIRC_B;
      S_CIRC_B: state_next = S_CIRC_C;
      S_CIRC_C: state_next = S_CIRC_D;
      S_CIRC_D: state_next = S_FIN;
      S_FIN:    if (fin_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- polygon edge stage ----------------
  logic signed [COORD_W-1:0] pt_x, pt_y;
  vertex_t                   first_v, prev_v, vi, vj;
  logic                      edge_sel, straddle, edge_neg, mul_neg;
  logic                      parity;
  logic signed [MUL_W-1:0]   op_a1, op_b1, op_a2, op_b2;
  logic signed [PROD_W-1:0]  p1, p2;
  logic signed [PROD_W:0]    sum_d;
  logic signed [MUL_W-1:0]   dxc, dyc;

  always_comb begin
    edge_sel = 1'b0;
    vi       = ring_q[0];
    vj       = prev_v;
    if (step != '0 && step < count) begin
      edge_sel = 1'b1;
    end else if (step != '0 && step == count) begin
      // closing edge from the last vertex back to the first
      edge_sel = 1'b1;
      vi       = first_v;
    end
  end

  assign straddle = (vi.y > pt_y) != (vj.y > pt_y);

  // circle operands: doubled point minus both drag ends
  assign dxc = MUL_W'(signed'({pt_x, 1'b0})) - sxq - exq;
  assign dyc = MUL_W'(signed'({pt_y, 1'b0})) - syq - eyq;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_v <= 1'b0;
    end else begin
      edge_v <= (state == S_POLY) && edge_sel && straddle;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pt_x <= in_ch.coord_x;
      pt_y <= in_ch.coord_y;
    end
    if (state == S_POLY) begin
      if (step == '0) begin
        first_v <= ring_q[0];
        prev_v  <= ring_q[0];
      end else if (step < count) begin
        prev_v <= ring_q[0];
      end
    end
    mul_neg <= edge_neg;
    case (state)
      S_POLY: begin
        op_a1    <= MUL_W'(pt_x) - MUL_W'(vi.x);
        op_b1    <= MUL_W'(vj.y) - MUL_W'(vi.y);
        op_a2    <= MUL_W'(vj.x) - MUL_W'(vi.x);
        op_b2    <= MUL_W'(pt_y) - MUL_W'(vi.y);
        edge_neg <= vj.y < vi.y;
      end
      S_CIRC_A: begin
        op_a1 <= dxc;
        op_b1 <= dxc;
        op_a2 <= dyc;
        op_b2 <= dyc;
      end
      S_CIRC_B: begin
        op_a1 <= exq - sxq;
        op_b1 <= exq - sxq;
        op_a2 <= eyq - syq;
        op_b2 <= eyq - syq;
      end
      default: ;
    endcase
    if (state == S_CIRC_C) begin
      sum_d <= (PROD_W + 1)'(p1) + (PROD_W + 1)'(p2);
    end
  end

  srht_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .in_v  (edge_v),
    .a1    (op_a1),
    .b1    (op_b1),
    .a2    (op_a2),
    .b2    (op_b2),
    .out_v (mul_v),
    .p1    (p1),
    .p2    (p2)
  );

  // crossing: lhs < rhs for a rising edge, reversed for a falling one
  logic crossing;
  assign crossing = mul_neg ? (p1 > p2) : (p1 < p2);

  // ---------------- step counter, vertex count, results ----------------
  logic              res_inside;
  status_e           res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      count  <= '0;
      parity <= 1'b0;
    end else begin
      if (accept) begin
        step   <= '0;
        parity <= 1'b0;
        case (in_op)
          OP_ADD:   if (add_ok) count <= count + 1'b1;
          OP_UNDO:  if (count != '0) count <= count - 1'b1;
          OP_CLEAR: count <= '0;
          default: ;
        endcase
      end else if (state == S_POLY) begin
        step <= step + 1'b1;
      end
      if (mul_v && crossing) begin
        parity <= ~parity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_inside <= 1'b0;
      res_status <= ST_OK;
      case (in_op)
        OP_TEST: begin
          case (shape)
            SHAPE_RECT: res_inside <= rect_hit;
            SHAPE_POLY: if (count < CNT_W'(MIN_POLY)) res_status <= ST_SHORT;
            default: ;
          endcase
        end
        OP_ADD:  if (!add_ok) res_status <= ST_FULL;
        OP_UNDO: if (count == '0) res_status <= ST_EMPTY;
        default: ;
      endcase
    end else if (state == S_DRAIN && !edge_v && !mul_v) begin
      res_inside <= parity;
    end else if (state == S_CIRC_D) begin
      res_inside <= sum_d <= ((PROD_W + 1)'(p1) + (PROD_W + 1)'(p2));
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (fin_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_ch.inside_res   <= res_inside;
      out_ch.vertex_count <= count;
      out_ch.status       <= res_status;
    end
  end

  // ---------------- assertions ----------------
  a_count_max : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  a_step_max : assert property (@(posedge clk) disable iff (rst)
    state == S_POLY |-> step <= CNT_W'(MAX_VERTICES))
    else $error("ring walk ran past store depth");

  a_short_zero : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status == ST_SHORT |-> !out_ch.inside_res)
    else $error("short polygon reported a hit");

  a_full_count : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status == ST_FULL |-> out_ch.vertex_count == CNT_W'(MAX_VERTICES))
    else $error("full status without a full store");

  a_busy_no_accept : assert property (@(posedge clk) disable iff (rst)
    (state == S_POLY || state == S_DRAIN) |-> !in_ch.ready)
    else $error("input taken during polygon walk");

endmodule

`default_nettype wire
